### rtl/alif_pkg.sv
`default_nettype none

package alif_pkg;

   // fixed point and datapath widths
   localparam int unsigned FRAC_W    = 16;
   localparam int unsigned MUL_A_W   = 34;
   localparam int unsigned MUL_B_W   = 25;
   localparam int unsigned PROD_W    = MUL_A_W + MUL_B_W;
   localparam int unsigned ACC_W     = 52;
   localparam int unsigned VSUM_W    = 40;
   localparam int unsigned THR_W     = 34;
   localparam int unsigned DIFF_W    = 35;
   localparam int unsigned CSR_IDX_W = 3;

   // rounding offset and one in q16.16
   localparam logic [FRAC_W-1:0] ROUND_HALF = 16'h8000;
   localparam logic [24:0]       ONE_Q16    = 25'h0010000;

   // register reset values
   localparam logic [15:0]        RST_LEAK_FACTOR      = 16'd59299;
   localparam logic [15:0]        RST_INPUT_GAIN       = 16'd249;
   localparam logic [15:0]        RST_ADAPT_DECAY      = 16'd59299;
   localparam logic [30:0]        RST_BASE_THRESHOLD   = 31'd983040;
   localparam logic [23:0]        RST_ADAPT_STRENGTH   = 24'd65536;
   localparam logic signed [31:0] RST_BIAS_CURRENT     = 32'sd0;
   localparam logic [7:0]         RST_REFRACTORY_TICKS = 8'd20;
   localparam logic [15:0]        RST_UPDATE_PERIOD    = 16'd1000;

   // register indexes on the csr port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEAK_FACTOR      = 3'd0,
      CSR_INPUT_GAIN       = 3'd1,
      CSR_ADAPT_DECAY      = 3'd2,
      CSR_BASE_THRESHOLD   = 3'd3,
      CSR_ADAPT_STRENGTH   = 3'd4,
      CSR_BIAS_CURRENT     = 3'd5,
      CSR_REFRACTORY_TICKS = 3'd6,
      CSR_UPDATE_PERIOD    = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [15:0]        leak_factor;
      logic [15:0]        input_gain;
      logic [15:0]        adapt_decay;
      logic [30:0]        base_threshold;
      logic [23:0]        adapt_strength;
      logic signed [31:0] bias_current;
      logic [7:0]         refractory_ticks;
      logic [15:0]        update_period;
   } cfg_type;

   typedef struct packed {
      logic signed [31:0] spike_sum;
      logic signed [31:0] next_current;
   } req_type;

   typedef struct packed {
      logic               spike_out;
      logic signed [31:0] membrane;
      logic signed [31:0] distance_to_threshold;
      logic               refractory_now;
   } rsp_type;

   // sequencer states, one multiplier pass each from ST_ADAPT to ST_THR
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADAPT,
      ST_GAIN,
      ST_LEAK,
      ST_THR,
      ST_POT,
      ST_FIRE
   } state_type;

   typedef enum logic [1:0] {
      MUL_ADAPT,
      MUL_GAIN,
      MUL_LEAK,
      MUL_THR
   } mul_sel_type;

   typedef struct packed {
      logic        accept;
      mul_sel_type mul_sel;
      logic        adapt_upd;
      logic        acc_load;
      logic        acc_add;
      logic        pot_upd;
      logic        finish;
   } ctrl_type;

endpackage

`default_nettype wire

### rtl/alif_mul.sv
`default_nettype none

module alif_mul (
   input  wire logic                                 clock,
   input  wire logic signed [alif_pkg::MUL_A_W-1:0]  mul_a,
   input  wire logic signed [alif_pkg::MUL_B_W-1:0]  mul_b,
   output logic signed [alif_pkg::PROD_W-1:0]        prod_ff
);

   logic signed [alif_pkg::PROD_W-1:0] prod_in;

   // signed product, both operands sign extended to the full width
   always_comb begin
      prod_in = alif_pkg::PROD_W'(mul_a) * alif_pkg::PROD_W'(mul_b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

`default_nettype wire

### rtl/alif_csr.sv
`default_nettype none

module alif_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           csr_write_en,
   input  wire logic [alif_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]                    csr_wdata,
   output alif_pkg::cfg_type                   cfg_ff
);

   alif_pkg::cfg_type cfg_in;

   // decode the register write
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            alif_pkg::CSR_LEAK_FACTOR:      cfg_in.leak_factor      = csr_wdata[15:0];
            alif_pkg::CSR_INPUT_GAIN:       cfg_in.input_gain       = csr_wdata[15:0];
            alif_pkg::CSR_ADAPT_DECAY:      cfg_in.adapt_decay      = csr_wdata[15:0];
            alif_pkg::CSR_BASE_THRESHOLD:   cfg_in.base_threshold   = csr_wdata[30:0];
            alif_pkg::CSR_ADAPT_STRENGTH:   cfg_in.adapt_strength   = csr_wdata[23:0];
            alif_pkg::CSR_BIAS_CURRENT:     cfg_in.bias_current     = csr_wdata;
            alif_pkg::CSR_REFRACTORY_TICKS: cfg_in.refractory_ticks = csr_wdata[7:0];
            alif_pkg::CSR_UPDATE_PERIOD:    cfg_in.update_period    = csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.leak_factor      <= alif_pkg::RST_LEAK_FACTOR;
         cfg_ff.input_gain       <= alif_pkg::RST_INPUT_GAIN;
         cfg_ff.adapt_decay      <= alif_pkg::RST_ADAPT_DECAY;
         cfg_ff.base_threshold   <= alif_pkg::RST_BASE_THRESHOLD;
         cfg_ff.adapt_strength   <= alif_pkg::RST_ADAPT_STRENGTH;
         cfg_ff.bias_current     <= alif_pkg::RST_BIAS_CURRENT;
         cfg_ff.refractory_ticks <= alif_pkg::RST_REFRACTORY_TICKS;
         cfg_ff.update_period    <= alif_pkg::RST_UPDATE_PERIOD;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

### rtl/alif_ctrl.sv
`default_nettype none

module alif_ctrl (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           req_valid,
   input  wire logic           rsp_free,
   output logic                req_ready,
   output alif_pkg::ctrl_type  ctl
);

   alif_pkg::state_type state_ff;
   alif_pkg::state_type state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         alif_pkg::ST_IDLE: begin
            if (req_valid) state_in = alif_pkg::ST_ADAPT;
         end
         alif_pkg::ST_ADAPT: state_in = alif_pkg::ST_GAIN;
         alif_pkg::ST_GAIN:  state_in = alif_pkg::ST_LEAK;
         alif_pkg::ST_LEAK:  state_in = alif_pkg::ST_THR;
         alif_pkg::ST_THR:   state_in = alif_pkg::ST_POT;
         alif_pkg::ST_POT:   state_in = alif_pkg::ST_FIRE;
         alif_pkg::ST_FIRE: begin
            if (rsp_free) state_in = alif_pkg::ST_IDLE;
         end
         default: state_in = alif_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= alif_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // per-state strobes for the datapath
   always_comb begin
      req_ready     = (state_ff == alif_pkg::ST_IDLE);
      ctl           = '0;
      ctl.mul_sel   = alif_pkg::MUL_ADAPT;
      case (state_ff)
         alif_pkg::ST_IDLE: begin
            ctl.accept = req_valid;
         end
         alif_pkg::ST_ADAPT: begin
            ctl.mul_sel = alif_pkg::MUL_ADAPT;
         end
         alif_pkg::ST_GAIN: begin
            ctl.mul_sel   = alif_pkg::MUL_GAIN;
            ctl.adapt_upd = 1'b1;
         end
         alif_pkg::ST_LEAK: begin
            ctl.mul_sel  = alif_pkg::MUL_LEAK;
            ctl.acc_load = 1'b1;
         end
         alif_pkg::ST_THR: begin
            ctl.mul_sel = alif_pkg::MUL_THR;
            ctl.acc_add = 1'b1;
         end
         alif_pkg::ST_POT: begin
            ctl.pot_upd = 1'b1;
         end
         alif_pkg::ST_FIRE: begin
            ctl.finish = rsp_free;
         end
         default: ;
      endcase
   end

endmodule

`default_nettype wire

### rtl/adaptive_lif_neuron_step_core.sv
`default_nettype none

// channel   ports                          direction  beat
// req       req_valid/req_ready/req_data   in         one tick: spike_sum, next_current
// rsp       rsp_valid/rsp_ready/rsp_data   out        one result per tick
// csr       csr_write_en/csr_index/...     in         register write, no handshake
//
// a tick steps from accept through ADAPT, GAIN, LEAK, THR, POT and FIRE, then back to IDLE:
// four passes through the one registered multiplier, then a potential and a compare step
// the result register lets a new tick be accepted while the last result still waits
// a stalled result holds the sequencer in its last step until the register drains
// synchronous reset clears the neuron state and loads the register defaults

module adaptive_lif_neuron_step_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire alif_pkg::req_type              req_data,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output alif_pkg::rsp_type                   rsp_data,
   input  wire logic                           csr_write_en,
   input  wire logic [alif_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]                    csr_wdata
);

   alif_pkg::cfg_type  cfg;
   alif_pkg::ctrl_type ctl;
   logic               rsp_free;

   logic signed [alif_pkg::MUL_A_W-1:0] mul_a;
   logic signed [alif_pkg::MUL_B_W-1:0] mul_b;
   logic signed [alif_pkg::PROD_W-1:0]  prod_ff;

   // neuron state
   logic signed [31:0] potential_ff, potential_in;
   logic [23:0]        adaptation_ff, adaptation_in;
   logic signed [31:0] held_ff, held_in;
   logic [7:0]         refr_ff, refr_in;
   logic               pending_ff, pending_in;
   logic [15:0]        phase_ff, phase_in;

   // per tick working registers
   logic signed [31:0]               spike_ff, spike_in;
   logic signed [32:0]               cur_sum_ff, cur_sum_in;
   logic signed [alif_pkg::ACC_W-1:0] acc_ff, acc_in;
   logic [alif_pkg::THR_W-1:0]       thr_ff, thr_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   alif_pkg::rsp_type                rsp_ff, rsp_in;

   // intermediate values
   logic                              boundary;
   logic [16:0]                       phase_inc;
   logic [40:0]                       adapt_rnd;
   logic [24:0]                       adapt_inc;
   logic [23:0]                       adapt_dec;
   logic signed [alif_pkg::ACC_W-1:0] acc_rnd;
   logic signed [alif_pkg::VSUM_W-1:0] vsum;
   logic [48:0]                       thr_rnd;
   logic signed [alif_pkg::DIFF_W-1:0] diff;
   logic                              fire;

   function automatic logic signed [31:0] sat32(input logic signed [alif_pkg::VSUM_W-1:0] v);
      logic signed [31:0] r;
      if (v[alif_pkg::VSUM_W-1:31] == '0 || v[alif_pkg::VSUM_W-1:31] == '1) begin
         r = v[31:0];
      end else if (v[alif_pkg::VSUM_W-1]) begin
         r = {1'b1, 31'd0};
      end else begin
         r = {1'b0, {31{1'b1}}};
      end
      return r;
   endfunction

   alif_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg_ff       (cfg)
   );

   alif_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .rsp_free  (rsp_free),
      .req_ready (req_ready),
      .ctl       (ctl)
   );

   // operand select for the shared multiplier
   always_comb begin
      case (ctl.mul_sel)
         alif_pkg::MUL_ADAPT: begin
            mul_a = alif_pkg::MUL_A_W'(adaptation_ff);
            mul_b = alif_pkg::MUL_B_W'(cfg.adapt_decay);
         end
         alif_pkg::MUL_GAIN: begin
            mul_a = alif_pkg::MUL_A_W'(cur_sum_ff);
            mul_b = alif_pkg::MUL_B_W'(cfg.input_gain);
         end
         alif_pkg::MUL_LEAK: begin
            mul_a = alif_pkg::MUL_A_W'(potential_ff);
            mul_b = alif_pkg::MUL_B_W'(cfg.leak_factor);
         end
         alif_pkg::MUL_THR: begin
            mul_a = alif_pkg::MUL_A_W'(cfg.adapt_strength);
            mul_b = alif_pkg::MUL_B_W'(adaptation_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   alif_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod_ff)
   );

   assign rsp_free = !rsp_valid_ff || rsp_ready;

   // rounded pieces taken from the product and accumulator
   always_comb begin
      boundary  = (phase_ff == 16'd1) || (cfg.update_period <= 16'd1);
      phase_inc = {1'b0, phase_ff} + 17'd1;

      adapt_rnd = {1'b0, prod_ff[39:0]} + 41'(alif_pkg::ROUND_HALF);
      adapt_dec = adapt_rnd[39:alif_pkg::FRAC_W];
      adapt_inc = {1'b0, adapt_dec} + alif_pkg::ONE_Q16;

      acc_rnd = acc_ff + alif_pkg::ACC_W'(alif_pkg::ROUND_HALF);
      vsum    = alif_pkg::VSUM_W'(signed'(acc_rnd[alif_pkg::ACC_W-1:alif_pkg::FRAC_W]))
              + alif_pkg::VSUM_W'(spike_ff)
              - (pending_ff ? alif_pkg::VSUM_W'(cfg.base_threshold) : '0);

      thr_rnd = {1'b0, prod_ff[47:0]} + 49'(alif_pkg::ROUND_HALF);

      diff = alif_pkg::DIFF_W'(potential_ff) - alif_pkg::DIFF_W'(thr_ff);
      fire = !diff[alif_pkg::DIFF_W-1] && (refr_ff == 8'd0);
   end

   // next values of state and working registers
   always_comb begin
      potential_in  = potential_ff;
      adaptation_in = adaptation_ff;
      held_in       = held_ff;
      refr_in       = refr_ff;
      pending_in    = pending_ff;
      phase_in      = phase_ff;
      spike_in      = spike_ff;
      cur_sum_in    = cur_sum_ff;
      acc_in        = acc_ff;
      thr_in        = thr_ff;
      rsp_in        = rsp_ff;

      // take the beat, clear state on a period boundary
      if (ctl.accept) begin
         if (boundary) begin
            potential_in  = '0;
            adaptation_in = '0;
            refr_in       = '0;
            pending_in    = 1'b0;
            spike_in      = '0;
         end else begin
            spike_in = req_data.spike_sum;
         end
         cur_sum_in = 33'(held_ff) + 33'(cfg.bias_current);
         held_in    = req_data.next_current;
         phase_in   = (phase_inc >= {1'b0, cfg.update_period}) ? '0 : phase_inc[15:0];
      end

      // decayed adaptation, plus one after a spike
      if (ctl.adapt_upd) begin
         if (pending_ff) begin
            adaptation_in = adapt_inc[24] ? '1 : adapt_inc[23:0];
         end else begin
            adaptation_in = adapt_dec;
         end
      end

      // sum of the current and leak products
      if (ctl.acc_load) begin
         acc_in = alif_pkg::ACC_W'(prod_ff);
      end
      if (ctl.acc_add) begin
         acc_in = acc_ff + alif_pkg::ACC_W'(prod_ff);
      end

      // new potential, adaptive threshold, refractory load
      if (ctl.pot_upd) begin
         potential_in = sat32(vsum);
         thr_in = alif_pkg::THR_W'(cfg.base_threshold) + alif_pkg::THR_W'(thr_rnd[48:alif_pkg::FRAC_W]);
         if (pending_ff && cfg.refractory_ticks != 8'd0) begin
            refr_in = cfg.refractory_ticks - 8'd1;
         end
      end

      // firing decision and result
      if (ctl.finish) begin
         pending_in       = fire;
         rsp_in.spike_out = fire;
         rsp_in.membrane  = potential_ff;
         if (refr_ff != 8'd0) begin
            rsp_in.refractory_now        = 1'b1;
            rsp_in.distance_to_threshold = 32'(cfg.base_threshold);
            refr_in                      = refr_ff - 8'd1;
         end else begin
            rsp_in.refractory_now        = 1'b0;
            rsp_in.distance_to_threshold = sat32(alif_pkg::VSUM_W'(diff));
         end
      end
   end

   // result register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         potential_ff  <= '0;
         adaptation_ff <= '0;
         held_ff       <= '0;
         refr_ff       <= '0;
         pending_ff    <= 1'b0;
         phase_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         potential_ff  <= potential_in;
         adaptation_ff <= adaptation_in;
         held_ff       <= held_in;
         refr_ff       <= refr_in;
         pending_ff    <= pending_in;
         phase_ff      <= phase_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      spike_ff   <= spike_in;
      cur_sum_ff <= cur_sum_in;
      acc_ff     <= acc_in;
      thr_ff     <= thr_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // a result is only written into a free output register
   assert property (@(posedge clock) disable iff (reset) ctl.finish |-> rsp_free)
      else $error("result written over an untaken beat");

   // the sequencer is busy right after taking a beat
   assert property (@(posedge clock) disable iff (reset) (req_valid && req_ready) |=> !req_ready)
      else $error("second beat taken while a tick is in progress");

   // a finished tick shows up on the output
   assert property (@(posedge clock) disable iff (reset) ctl.finish |=> rsp_valid_ff)
      else $error("finished tick not presented");

   // a refractory neuron never fires
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_ff.spike_out && rsp_ff.refractory_now))
      else $error("spike during refractory period");

endmodule

`default_nettype wire

### tb/adaptive_lif_neuron_step_core_tb.sv
`timescale 1ns / 1ps

module adaptive_lif_neuron_step_core_tb;

   localparam int unsigned CYCLE_LIMIT     = 200000;
   localparam int unsigned RANDOM_PHASES   = 8;
   localparam int unsigned TICKS_PER_PHASE = 100;
   localparam int unsigned SETTLE_CYCLES   = 10;
   localparam int unsigned LONG_HOLD       = 300;

   // predicts each tick of the neuron and holds the results still to come
   class alif_tick_ledger;
      alif_pkg::cfg_type  cfg;
      logic signed [31:0] potential;
      logic [23:0]        adaptation;
      logic signed [31:0] held_current;
      logic [7:0]         refractory_left;
      bit                 reset_pending;
      logic [15:0]        tick_phase;
      alif_pkg::rsp_type  awaited_results[$];
      int unsigned        mismatch_count;

      function new();
         cfg = '{alif_pkg::RST_LEAK_FACTOR, alif_pkg::RST_INPUT_GAIN,
                 alif_pkg::RST_ADAPT_DECAY, alif_pkg::RST_BASE_THRESHOLD,
                 alif_pkg::RST_ADAPT_STRENGTH, alif_pkg::RST_BIAS_CURRENT,
                 alif_pkg::RST_REFRACTORY_TICKS, alif_pkg::RST_UPDATE_PERIOD};
         potential       = '0;
         adaptation      = '0;
         held_current    = '0;
         refractory_left = '0;
         reset_pending   = 1'b0;
         tick_phase      = '0;
         mismatch_count  = 0;
      endfunction

      // product back to q16 with round half up
      function longint round_q16(longint v);
         return (v + 64'sd32768) >>> 16;
      endfunction

      function logic signed [31:0] clamp32(longint v);
         if (v > 64'sd2147483647)
            return 32'sh7FFFFFFF;
         if (v < -64'sd2147483648)
            return 32'sh80000000;
         return v[31:0];
      endfunction

      // register write, cut to the register width
      function void apply_setting(alif_pkg::csr_index_type idx, logic [31:0] value);
         case (idx)
            alif_pkg::CSR_LEAK_FACTOR:      cfg.leak_factor      = value[15:0];
            alif_pkg::CSR_INPUT_GAIN:       cfg.input_gain       = value[15:0];
            alif_pkg::CSR_ADAPT_DECAY:      cfg.adapt_decay      = value[15:0];
            alif_pkg::CSR_BASE_THRESHOLD:   cfg.base_threshold   = value[30:0];
            alif_pkg::CSR_ADAPT_STRENGTH:   cfg.adapt_strength   = value[23:0];
            alif_pkg::CSR_BIAS_CURRENT:     cfg.bias_current     = value;
            alif_pkg::CSR_REFRACTORY_TICKS: cfg.refractory_ticks = value[7:0];
            alif_pkg::CSR_UPDATE_PERIOD:    cfg.update_period    = value[15:0];
            default: ;
         endcase
      endfunction

      // one neuron tick for an accepted input beat
      function void note_tick(alif_pkg::req_type beat);
         longint  spike, v, thr, gap_to_thr, adapt;
         longint  gain, leak, decay, strength, base, bias, held, pot;
         int unsigned next_phase;
         alif_pkg::rsp_type res;
         spike    = $signed(beat.spike_sum);
         gain     = cfg.input_gain;
         leak     = cfg.leak_factor;
         decay    = cfg.adapt_decay;
         strength = cfg.adapt_strength;
         base     = cfg.base_threshold;
         bias     = $signed(cfg.bias_current);

         // period boundary clears the state and drops the spike input
         if (tick_phase == 16'd1 || cfg.update_period <= 16'd1) begin
            potential       = '0;
            adaptation      = '0;
            refractory_left = '0;
            reset_pending   = 1'b0;
            spike           = 0;
         end

         adapt = adaptation;
         adapt = round_q16(adapt * decay);

         // leak and integrate
         pot  = potential;
         held = held_current;
         v    = round_q16(gain * (held + bias) + leak * pot) + spike;

         // reset after the previous spike
         if (reset_pending) begin
            v     = v - base;
            adapt = adapt + 64'sd65536;
            if (adapt > 64'sd16777215)
               adapt = 64'sd16777215;
            reset_pending = 1'b0;
            if (cfg.refractory_ticks != 8'd0)
               refractory_left = cfg.refractory_ticks - 8'd1;
         end
         potential  = clamp32(v);
         adaptation = adapt[23:0];
         pot        = potential;

         // adaptive threshold and firing
         thr = base + round_q16(strength * adapt);
         res.spike_out = 1'b0;
         if (pot >= thr && refractory_left == 8'd0) begin
            res.spike_out = 1'b1;
            reset_pending = 1'b1;
         end
         if (refractory_left != 8'd0) begin
            res.refractory_now = 1'b1;
            gap_to_thr         = base;
            refractory_left    = refractory_left - 8'd1;
         end else begin
            res.refractory_now = 1'b0;
            gap_to_thr         = pot - thr;
         end
         res.membrane              = potential;
         res.distance_to_threshold = clamp32(gap_to_thr);

         held_current = beat.next_current;
         next_phase   = tick_phase + 1;
         if (next_phase >= cfg.update_period)
            tick_phase = '0;
         else
            tick_phase = next_phase[15:0];
         awaited_results.push_back(res);
      endfunction

      function void flag_field(string name, logic signed [31:0] want, logic signed [31:0] got);
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
         mismatch_count++;
      endfunction

      // compare a result beat with the oldest prediction
      function void check_result(alif_pkg::rsp_type got);
         alif_pkg::rsp_type want;
         if (awaited_results.size() == 0) begin
            $display("%0t: result beat with no tick outstanding, got %p", $time, got);
            mismatch_count++;
            return;
         end
         want = awaited_results.pop_front();
         if (got.spike_out !== want.spike_out)
            flag_field("spike_out", want.spike_out, got.spike_out);
         if (got.membrane !== want.membrane)
            flag_field("membrane", want.membrane, got.membrane);
         if (got.distance_to_threshold !== want.distance_to_threshold)
            flag_field("distance_to_threshold", want.distance_to_threshold,
                       got.distance_to_threshold);
         if (got.refractory_now !== want.refractory_now)
            flag_field("refractory_now", want.refractory_now, got.refractory_now);
      endfunction
   endclass

   logic                           clock        = 1'b0;
   logic                           reset        = 1'b1;
   logic                           req_valid    = 1'b0;
   logic                           req_ready;
   alif_pkg::req_type              req_data     = '0;
   logic                           rsp_valid;
   logic                           rsp_ready    = 1'b0;
   alif_pkg::rsp_type              rsp_data;
   logic                           csr_write_en = 1'b0;
   logic [alif_pkg::CSR_IDX_W-1:0] csr_index    = '0;
   logic [31:0]                    csr_wdata    = '0;

   alif_tick_ledger ledger;
   int unsigned     idle_pct     = 0;
   int unsigned     stall_pct    = 0;
   int unsigned     hold_request = 0;
   int unsigned     hold_left    = 0;
   int unsigned     cycle_count  = 0;

   adaptive_lif_neuron_step_core i_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // beats accepted on either channel
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            ledger.note_tick(req_data);
         if (rsp_valid && rsp_ready)
            ledger.check_result(rsp_data);
      end
   end

   // result side back-pressure, with an occasional long hold
   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_tick(alif_pkg::req_type beat);
      // random idle cycles ahead of the beat
      while ($urandom_range(99) < idle_pct) begin
         @(negedge clock);
         req_valid <= 1'b0;
         req_data  <= alif_pkg::req_type'({$urandom, $urandom});
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= beat;
      do
         @(posedge clock);
      while (!req_ready);
   endtask

   task automatic finish_sending();
      @(negedge clock);
      req_valid <= 1'b0;
   endtask

   task automatic drain();
      while (ledger.awaited_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(alif_pkg::csr_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      ledger.apply_setting(idx, value);
   endtask

   task automatic close_writes();
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // register value with a bias towards the extremes
   function automatic logic [31:0] pick_setting(alif_pkg::csr_index_type idx);
      int unsigned roll;
      logic [31:0] val;
      logic [31:0] keep;
      roll = $urandom_range(99);
      case (idx)
         alif_pkg::CSR_LEAK_FACTOR, alif_pkg::CSR_ADAPT_DECAY: begin
            keep = 32'hFFFF;
            if (roll < 10)      val = 0;
            else if (roll < 25) val = 32'hFFFF;
            else if (roll < 35) val = $urandom_range(65535);
            else                val = $urandom_range(65535, 45000);
         end
         alif_pkg::CSR_INPUT_GAIN: begin
            keep = 32'hFFFF;
            if (roll < 10)      val = 0;
            else if (roll < 20) val = 32'hFFFF;
            else if (roll < 30) val = $urandom_range(65535);
            else                val = $urandom_range(4096);
         end
         alif_pkg::CSR_BASE_THRESHOLD: begin
            keep = 32'h7FFFFFFF;
            if (roll < 10)      val = 0;
            else if (roll < 20) val = 32'h7FFFFFFF;
            else                val = $urandom_range(32'h400000, 32'h4000);
         end
         alif_pkg::CSR_ADAPT_STRENGTH: begin
            keep = 32'hFFFFFF;
            if (roll < 10)      val = 0;
            else if (roll < 20) val = 32'hFFFFFF;
            else                val = $urandom_range(32'h40000);
         end
         alif_pkg::CSR_BIAS_CURRENT: begin
            keep = 32'hFFFFFFFF;
            if (roll < 10)      val = 32'h7FFFFFFF;
            else if (roll < 20) val = 32'h80000000;
            else if (roll < 30) val = $urandom;
            else if (roll < 55) val = 0;
            else                val = $urandom_range(32'h400000) - 32'h200000;
         end
         alif_pkg::CSR_REFRACTORY_TICKS: begin
            keep = 32'hFF;
            if (roll < 10)      val = 0;
            else if (roll < 20) val = 255;
            else if (roll < 30) val = 1;
            else                val = $urandom_range(30);
         end
         default: begin
            keep = 32'hFFFF;
            if (roll < 5)       val = 0;
            else if (roll < 10) val = 1;
            else if (roll < 20) val = 32'hFFFF;
            else                val = $urandom_range(200, 2);
         end
      endcase
      // stray bits above the register width now and then
      if ($urandom_range(3) == 0)
         val = val | ($urandom & ~keep);
      return val;
   endfunction

   task automatic load_random_settings();
      write_reg(alif_pkg::CSR_LEAK_FACTOR, pick_setting(alif_pkg::CSR_LEAK_FACTOR));
      write_reg(alif_pkg::CSR_INPUT_GAIN, pick_setting(alif_pkg::CSR_INPUT_GAIN));
      write_reg(alif_pkg::CSR_ADAPT_DECAY, pick_setting(alif_pkg::CSR_ADAPT_DECAY));
      write_reg(alif_pkg::CSR_BASE_THRESHOLD, pick_setting(alif_pkg::CSR_BASE_THRESHOLD));
      write_reg(alif_pkg::CSR_ADAPT_STRENGTH, pick_setting(alif_pkg::CSR_ADAPT_STRENGTH));
      write_reg(alif_pkg::CSR_BIAS_CURRENT, pick_setting(alif_pkg::CSR_BIAS_CURRENT));
      write_reg(alif_pkg::CSR_REFRACTORY_TICKS,
                pick_setting(alif_pkg::CSR_REFRACTORY_TICKS));
      write_reg(alif_pkg::CSR_UPDATE_PERIOD, pick_setting(alif_pkg::CSR_UPDATE_PERIOD));
      close_writes();
   endtask

   // q16 level: mostly within a span leaning positive, some zeros and extremes
   function automatic logic signed [31:0] pick_level(int unsigned span);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 8)
         return $urandom;
      if (roll < 14) begin
         case ($urandom_range(3))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2:       return -32'sd1;
            default: return 32'sd0;
         endcase
      end
      if (roll < 30)
         return 32'sd0;
      return $urandom_range(3 * span) - span;
   endfunction

   // spike input scaled to the threshold so that the neuron fires often
   function automatic alif_pkg::req_type random_tick();
      alif_pkg::req_type beat;
      int unsigned       span;
      span = ledger.cfg.base_threshold >> 2;
      if (span < 4096)
         span = 4096;
      if (span > 32'h1000000)
         span = 32'h1000000;
      beat.spike_sum    = pick_level(span);
      beat.next_current = pick_level(32'h10000 << (5 * $urandom_range(2)));
      return beat;
   endfunction

   initial begin
      ledger = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // default registers: extremes, saturation, the boundary tick drops its spike
      send_tick('{32'sd0, 32'sd0});
      send_tick('{32'sh7FFFFFFF, 32'sh7FFFFFFF});
      send_tick('{32'sh7FFFFFFF, 32'sh80000000});
      send_tick('{32'sh80000000, 32'sh80000000});
      send_tick('{32'sh80000000, 32'sh7FFFFFFF});
      send_tick('{-32'sd1, 32'sd0});
      send_tick('{32'sd983040, 32'sd65536});
      send_tick('{32'sd0, -32'sd65536});
      finish_sending();
      drain();

      // zero refractory length, short period, steep adaptation
      write_reg(alif_pkg::CSR_REFRACTORY_TICKS, 32'd0);
      write_reg(alif_pkg::CSR_UPDATE_PERIOD, 32'd3);
      write_reg(alif_pkg::CSR_BASE_THRESHOLD, 32'h10000);
      write_reg(alif_pkg::CSR_ADAPT_STRENGTH, 32'hFFFFFF);
      close_writes();
      repeat (6) send_tick('{32'sh00030000, 32'sh00100000});
      finish_sending();
      drain();

      // period of zero: every tick a boundary
      write_reg(alif_pkg::CSR_UPDATE_PERIOD, 32'd0);
      close_writes();
      repeat (3) send_tick('{32'sh00050000, 32'sd0});
      finish_sending();
      drain();

      // period shrunk below the running phase
      write_reg(alif_pkg::CSR_UPDATE_PERIOD, 32'd40);
      close_writes();
      repeat (6) send_tick('{32'sh00020000, 32'sh00040000});
      finish_sending();
      drain();
      write_reg(alif_pkg::CSR_UPDATE_PERIOD, 32'd4);
      close_writes();
      repeat (4) send_tick('{32'sh00020000, 32'sd0});
      finish_sending();
      drain();

      // random phases, each with fresh registers and one of four idling patterns
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p % 4)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 67;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 67;
            end
            default: begin
               idle_pct  = 20;
               stall_pct = 20;
            end
         endcase
         load_random_settings();
         // long receiver hold while beats keep coming
         if (p == 4)
            hold_request = LONG_HOLD;
         for (int n = 0; n < TICKS_PER_PHASE; n++) begin
            // sender pause until every result is back
            if (p == 5 && n == TICKS_PER_PHASE / 2) begin
               finish_sending();
               drain();
            end
            send_tick(random_tick());
         end
         finish_sending();
         drain();
      end

      if (ledger.mismatch_count == 0 && ledger.awaited_results.size() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule

### filelist.f
rtl/alif_pkg.sv
rtl/alif_mul.sv
rtl/alif_csr.sv
rtl/alif_ctrl.sv
rtl/adaptive_lif_neuron_step_core.sv
tb/adaptive_lif_neuron_step_core_tb.sv
